// File: hdl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the sorted min-priority queue
// Capacity, key type, action and status codes, channel payloads and the
// control and link structs that run along the row of cells.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		key_t       key_in;
	} req_t;

	typedef struct packed {
		key_t       smallest_key;
		logic       is_empty;
		logic [4:0] entry_count;
		logic [1:0] status;
	} rsp_t;

	// Broadcast to every cell for one accepted step.
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		key_t key;
	} cell_ctrl_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		key_t key;
		logic valid;
		logic gt;
	} cell_link_t;

endpackage

// File: hdl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted queue
// Holds one key with its valid bit. On a push it keeps its key, takes the new
// key, or takes its left neighbor's key; on a pop it takes its right
// neighbor's key; on a clear it empties.
// ----------------------------------------------------------------------------
module smpq_cell
	import smpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link,
	output key_t       key_d,
	output logic       valid_d
);

	key_t key_q;
	logic valid_q;
	logic gt;

	// An empty slot counts as larger than any key. Equal keys stay ahead of
	// the new one.
	assign gt = !valid_q || (ctrl.key < key_q);

	assign link.key   = key_q;
	assign link.valid = valid_q;
	assign link.gt    = gt;

	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		priority if (ctrl.clear) begin
			key_d   = '0;
			valid_d = 1'b0;
		end else if (ctrl.push) begin
			if (left.gt) begin
				key_d   = left.key;
				valid_d = left.valid;
			end else if (gt) begin
				key_d   = ctrl.key;
				valid_d = 1'b1;
			end
		end else if (ctrl.pop) begin
			key_d   = right.key;
			valid_d = right.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

// File: hdl/sorted_min_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_top: bounded min-priority queue on a row of cells
// Keys are kept in ascending signed order across a row of CAPACITY cells.
// Each request pushes, pops or clears and yields one response.
// ----------------------------------------------------------------------------
// A response is held in the output register, or in the skid entry on a stall.
// Throughput: one request per cycle while the skid entry is free; all cells
// update at once, so the row of comparators, one per cell, sets the pace.
// A two-entry output buffer lets a request transfer while a response waits.
// Reset empties the queue and the output buffer at once; there is no sweep.
module sorted_min_priority_queue_top
	import smpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Request transfer and the step it asks for.
	logic       accept;
	logic       full;
	logic       empty;
	logic [1:0] status;
	cell_ctrl_t ctrl;

	// Row of cells and the links between them. Link CAPACITY is the empty
	// slot to the right of the last cell; the left edge is a fixed link.
	cell_link_t links [CAPACITY+1];
	cell_link_t left_edge;
	key_t       cell_key_d [CAPACITY];
	logic       cell_valid_d [CAPACITY];
	key_t       head_key_d;
	logic       head_valid_d;

	// Stored count and its next value.
	cnt_t cnt_q;
	cnt_t cnt_d;
	logic [CNT_W+4:0] cnt_ext;

	// Response computed for the step and the output buffer.
	rsp_t res;
	rsp_t out_q;
	rsp_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic take_out;

	// A request is only held off while the skid entry is occupied.
	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !skid_valid_q;

	assign full  = (cnt_q == cnt_t'(CAPACITY));
	assign empty = (cnt_q == '0);

	// Push on a full queue and pop on an empty one leave every cell alone.
	// Action code 3 is a no-op that still reports the state.
	always_comb begin
		ctrl.push  = 1'b0;
		ctrl.pop   = 1'b0;
		ctrl.clear = 1'b0;
		ctrl.key   = req.key_in;
		status     = ST_OK;
		cnt_d      = cnt_q;
		if (accept) begin
			unique case (req.action)
				ACT_PUSH: begin
					if (full) begin
						status = ST_FULL;
					end else begin
						ctrl.push = 1'b1;
						cnt_d     = cnt_q + cnt_t'(1);
					end
				end
				ACT_POP: begin
					if (empty) begin
						status = ST_EMPTY;
					end else begin
						ctrl.pop = 1'b1;
						cnt_d    = cnt_q - cnt_t'(1);
					end
				end
				ACT_CLEAR: begin
					ctrl.clear = 1'b1;
					cnt_d      = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// The cell left of the head never shifts in: it is never "greater".
	assign left_edge.key   = '0;
	assign left_edge.valid = 1'b0;
	assign left_edge.gt    = 1'b0;

	assign links[CAPACITY].key   = '0;
	assign links[CAPACITY].valid = 1'b0;
	assign links[CAPACITY].gt    = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smpq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    ((i == 0) ? left_edge : links[(i == 0) ? 0 : i-1]),
			.right   (links[i+1]),
			.link    (links[i]),
			.key_d   (cell_key_d[i]),
			.valid_d (cell_valid_d[i])
		);
	end

	assign head_key_d   = cell_key_d[0];
	assign head_valid_d = cell_valid_d[0];

	// The response reports the state after the step; the head cell's next
	// value is the smallest key.
	assign cnt_ext = {5'b0, cnt_d};

	always_comb begin
		res.smallest_key = head_valid_d ? head_key_d : '0;
		res.is_empty     = (cnt_d == '0);
		res.entry_count  = cnt_ext[4:0];
		res.status       = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// Output buffer: the output register feeds the port, and the skid entry
	// catches a response whose request transferred while the port was stalled.
	assign take_out  = out_valid_q && !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || take_out) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

endmodule

// File: test/tb_sorted_min_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue_top: self-checking bench of the min-priority queue
// Push, pop, clear and no-op requests are sent in directed and random bursts
// under several idle and stall patterns. A mirror of the sorted key store
// predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue_top;
	import smpq_pkg::*;

	// The package names three actions; code 3 is a no-op that still reports.
	localparam logic [1:0] ACT_NOP = 2'd3;

	localparam int ITEMS_PER_PHASE = 400;
	localparam int CYCLE_LIMIT     = 200000;

	// Mirror of the queue: it keeps its own sorted copy of the stored keys and
	// the responses still owed by the block, oldest first.
	class min_queue_mirror;
		key_t keys [CAPACITY];
		int   stored;
		rsp_t awaited_rsp [$];
		int   mismatches;

		function new();
			foreach (keys[i]) keys[i] = '0;
			stored     = 0;
			mismatches = 0;
		endfunction

		// Applies one accepted request and queues the response it must cause.
		function void apply_request(req_t r);
			rsp_t       e;
			int         pos;
			logic [1:0] st;
			st = ST_OK;
			case (r.action)
				ACT_PUSH: begin
					if (stored >= CAPACITY) begin
						st = ST_FULL;
					end else begin
						// New key goes after any equal keys already stored.
						pos = stored;
						while (pos > 0 && $signed(r.key_in) < $signed(keys[pos-1])) begin
							keys[pos] = keys[pos-1];
							pos--;
						end
						keys[pos] = r.key_in;
						stored++;
					end
				end
				ACT_POP: begin
					if (stored == 0) begin
						st = ST_EMPTY;
					end else begin
						for (int i = 1; i < stored; i++) keys[i-1] = keys[i];
						stored--;
						keys[stored] = '0;
					end
				end
				ACT_CLEAR: begin
					foreach (keys[i]) keys[i] = '0;
					stored = 0;
				end
				default: begin
				end
			endcase
			e.smallest_key = (stored == 0) ? key_t'(0) : keys[0];
			e.is_empty     = (stored == 0);
			e.entry_count  = 5'(stored);
			e.status       = st;
			awaited_rsp.push_back(e);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		// Compares one accepted response with the oldest one owed.
		function void check_response(rsp_t got);
			rsp_t e;
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				$display("%0t ns: response with none expected, actual key %0h count %0d status %0d",
					$time, got.smallest_key, got.entry_count, got.status);
				return;
			end
			e = awaited_rsp.pop_front();
			field_check("smallest_key", e.smallest_key, got.smallest_key);
			field_check("is_empty", e.is_empty, got.is_empty);
			field_check("entry_count", e.entry_count, got.entry_count);
			field_check("status", e.status, got.status);
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	// The main sequence changes them from phase to phase.
	int req_idle_pct  = 0;
	int rsp_stall_pct = 0;
	int cycle_count   = 0;

	min_queue_mirror mirror;

	sorted_min_priority_queue_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Free-running clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The receiver decides afresh at each falling edge whether to hold off the
	// next response transfer.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	// Transfers are observed at the rising edge, where every input was set at the
	// falling edge before. A response always trails its request through the output
	// register, so checking before predicting in the same edge is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) mirror.check_response(rsp);
			if (req_valid && !req_stall) mirror.apply_request(req);
		end
	end

	// A hung block ends the run here instead of hanging the simulator.
	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic req_t make_req(logic [1:0] action, key_t key);
		req_t r;
		r.action = action;
		r.key_in = key;
		return r;
	endfunction

	// Keys are drawn from three pools: full-range noise, a narrow band of
	// whole numbers that yields many equal keys, and the corner values.
	function automatic key_t random_key();
		key_t corners [6];
		corners = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h7FFF_FFFE, 32'h7FFF_FFFF};
		case ($urandom_range(2))
			0: return key_t'($urandom());
			1: return key_t'(($signed($urandom_range(15)) - 8) * 65536);
			default: return corners[$urandom_range(5)];
		endcase
	endfunction

	// One random request. The push share steers a burst toward filling or
	// draining the queue; a few percent are no-ops and clears.
	function automatic req_t random_req(int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct) return make_req(ACT_PUSH, random_key());
		if (r < 96) return make_req(ACT_POP, key_t'($urandom()));
		if (r < 98) return make_req(ACT_NOP, key_t'($urandom()));
		return make_req(ACT_CLEAR, key_t'($urandom()));
	endfunction

	// Sends one request: idle cycles first as the current phase asks, then
	// holds the request until it is accepted. Returns at a falling edge with
	// nothing yet scheduled for that edge.
	task automatic send_req(req_t item);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			req       <= req_t'({$urandom(), $urandom()});
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Lowers valid and waits for the next falling edge, then until no response is
	// owed any more.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (mirror.awaited_rsp.size() != 0);
	endtask

	// Directed requests: pop on an empty queue, the extreme keys, a key equal
	// to the head, filling the queue to capacity, a push that is dropped when
	// full, a pop, a no-op, a clear, and a pop and a push after the clear.
	task automatic directed_reqs();
		send_req(make_req(ACT_POP, 32'h0000_0000));
		send_req(make_req(ACT_PUSH, 32'h7FFF_FFFF));
		send_req(make_req(ACT_PUSH, 32'h8000_0000));
		send_req(make_req(ACT_PUSH, 32'h8000_0000));
		send_req(make_req(ACT_PUSH, 32'h0000_0000));
		send_req(make_req(ACT_PUSH, 32'hFFFF_FFFF));
		for (int i = 0; i < 11; i++) begin
			send_req(make_req(ACT_PUSH, key_t'((5 - i) * 32'sh0001_8000)));
		end
		send_req(make_req(ACT_PUSH, 32'h0000_4000));
		send_req(make_req(ACT_POP, 32'hFFFF_FFFF));
		send_req(make_req(ACT_NOP, 32'hA5A5_5A5A));
		send_req(make_req(ACT_CLEAR, 32'h5A5A_A5A5));
		send_req(make_req(ACT_POP, 32'h0000_0000));
		send_req(make_req(ACT_PUSH, 32'h1234_5678));
	endtask

	// Random bursts: filling bursts push the queue into the full state,
	// draining bursts empty it, mixed bursts wander in between, and now and
	// then a lone clear or no-op.
	task automatic random_reqs(int count);
		int sent;
		int len;
		int push_pct;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					push_pct = 88;
					len      = $urandom_range(4, 24);
				end
				4, 5, 6: begin
					push_pct = 10;
					len      = $urandom_range(4, 24);
				end
				7, 8: begin
					push_pct = 50;
					len      = $urandom_range(1, 16);
				end
				default: begin
					push_pct = 0;
					len      = 1;
				end
			endcase
			for (int i = 0; i < len; i++) begin
				if (push_pct == 0)
					send_req(make_req($urandom_range(1) ? ACT_CLEAR : ACT_NOP,
						key_t'($urandom())));
				else
					send_req(random_req(push_pct));
			end
			sent += len;
		end
	endtask

	initial begin
		int idle_pcts  [4];
		int stall_pcts [4];
		idle_pcts  = '{0, 64, 0, 21};
		stall_pcts = '{0, 0, 64, 21};
		mirror = new();

		// Reset is held from the start and released at a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phase order: no idling, sender idle, receiver stalling, both. Each
		// phase ends with the sender paused until every response is in.
		for (int p = 0; p < 4; p++) begin
			req_idle_pct  = idle_pcts[p];
			rsp_stall_pct = stall_pcts[p];
			if (p == 0) directed_reqs();
			random_reqs(ITEMS_PER_PHASE);
			wait_drained();
		end

		// Waiting on past the last response owed catches any stray response.
		repeat (4) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited_rsp.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
